// ----- rtl/hrb_pkg.sv -----
// shared types and codes for the handshake retry backoff block
package hrb_pkg;

    localparam int OP_W     = 2;
    localparam int CNT_W    = 4;
    localparam int TICK_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 8;
    localparam int TDATA_W  = 8;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_SEG   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_SYN  = 2'd1;
    localparam logic [1:0] SEND_ACK  = 2'd2;

    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_BUSY      = 2'd1;
    localparam logic [1:0] ST_CONNECTED = 2'd2;
    localparam logic [1:0] ST_FAILED    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WAIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_QUIET    = 2'd2;

    localparam logic [CNT_W-1:0]  RST_MAX_ATTEMPTS = 4'd10;
    localparam logic [TICK_W-1:0] RST_INITIAL_WAIT = 8'd1;
    localparam logic [TICK_W-1:0] RST_ACK_QUIET    = 8'd5;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [2:0] {
        EV_START,
        EV_TICK,
        EV_SYNACK,
        EV_OTHER_SEG,
        EV_NOP
    } ev_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

// ----- rtl/hrb_front.sv -----
// input side: stream handshake and event classification
module hrb_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [hrb_pkg::TDATA_W-1:0]  s_tdata,
    input  logic [hrb_pkg::OP_W-1:0]     s_tuser,
    input  hrb_pkg::q_status_t           q_status,
    output logic                         push,
    output hrb_pkg::ev_t                 push_ev
);

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        unique case (s_tuser)
            hrb_pkg::OP_START: push_ev = hrb_pkg::EV_START;
            hrb_pkg::OP_TICK:  push_ev = hrb_pkg::EV_TICK;
            hrb_pkg::OP_SEG:   push_ev = s_tdata[0] ? hrb_pkg::EV_SYNACK
                                                    : hrb_pkg::EV_OTHER_SEG;
            hrb_pkg::OP_NONE:  push_ev = hrb_pkg::EV_NOP;
            default:           push_ev = hrb_pkg::EV_NOP;
        endcase
    end

endmodule

// ----- rtl/hrb_queue.sv -----
// two-entry event queue between front and back
module hrb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hrb_pkg::ev_t       push_ev,
    input  logic               pop,
    output hrb_pkg::ev_t       head_ev,
    output hrb_pkg::q_status_t status
);

    hrb_pkg::ev_t                   entry_reg [hrb_pkg::QDEPTH];
    logic [hrb_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [hrb_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [hrb_pkg::QCNT_W-1:0]     count_reg;
    logic [hrb_pkg::QCNT_W-1:0]     count_next;

    assign head_ev          = entry_reg[rd_ptr_reg];
    assign status.full      = (count_reg == hrb_pkg::QCNT_W'(hrb_pkg::QDEPTH));
    assign status.not_empty = (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_ev;
    end

endmodule

// ----- rtl/hrb_back.sv -----
// handshake state machine, backoff timer, config registers and output register
module hrb_back #(
    parameter int TIMER_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hrb_pkg::CFG_W-1:0]      cfg_data,
    input  hrb_pkg::ev_t                   head_ev,
    input  logic                           head_valid,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hrb_pkg::TDATA_W-1:0]    m_tdata
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_SYNACK,
        PH_WAIT_QUIET,
        PH_CONNECTED,
        PH_FAILED
    } phase_t;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    phase_t                       phase_reg, phase_next;
    logic [hrb_pkg::CNT_W-1:0]    attempt_reg, attempt_next;
    logic [TIMER_BITS-1:0]        wait_reg, wait_next;
    logic [TIMER_BITS-1:0]        ticks_reg, ticks_next;
    logic [hrb_pkg::CNT_W-1:0]    max_attempts_reg;
    logic [hrb_pkg::TICK_W-1:0]   initial_wait_reg;
    logic [hrb_pkg::TICK_W-1:0]   ack_quiet_reg;
    logic                         m_tvalid_reg;
    logic [1:0]                   send_reg, send_next;
    logic [1:0]                   status_reg, status_next;

    logic [TIMER_BITS-1:0]        ticks_inc;
    logic [TIMER_BITS-1:0]        wait_doubled;
    logic                         last_attempt;

    assign pop      = head_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(hrb_pkg::TDATA_W-4){1'b0}}, status_reg, send_reg};

    assign ticks_inc    = (ticks_reg == TIMER_MAX) ? ticks_reg : ticks_reg + 1'b1;
    assign wait_doubled = wait_reg[TIMER_BITS-1] ? TIMER_MAX
                                                 : {wait_reg[TIMER_BITS-2:0], 1'b0};
    assign last_attempt = (attempt_reg >= max_attempts_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        attempt_next = attempt_reg;
        wait_next    = wait_reg;
        ticks_next   = ticks_reg;
        send_next    = hrb_pkg::SEND_NONE;

        if (head_ev == hrb_pkg::EV_START)
        begin
            phase_next   = PH_WAIT_SYNACK;
            attempt_next = hrb_pkg::CNT_W'(1);
            wait_next    = TIMER_BITS'(initial_wait_reg);
            ticks_next   = '0;
            send_next    = hrb_pkg::SEND_SYN;
        end
        else if (head_ev == hrb_pkg::EV_TICK || head_ev == hrb_pkg::EV_SYNACK
                 || head_ev == hrb_pkg::EV_OTHER_SEG)
        begin
            if (phase_reg == PH_WAIT_SYNACK)
            begin
                if (head_ev == hrb_pkg::EV_SYNACK)
                begin
                    phase_next   = PH_WAIT_QUIET;
                    attempt_next = hrb_pkg::CNT_W'(1);
                    wait_next    = TIMER_BITS'(ack_quiet_reg);
                    ticks_next   = '0;
                    send_next    = hrb_pkg::SEND_ACK;
                end
                else if (head_ev == hrb_pkg::EV_OTHER_SEG || ticks_inc >= wait_reg)
                begin
                    if (head_ev == hrb_pkg::EV_TICK)
                        ticks_next = ticks_inc;
                    if (last_attempt)
                        phase_next = PH_FAILED;
                    else
                    begin
                        attempt_next = attempt_reg + 1'b1;
                        ticks_next   = '0;
                        wait_next    = wait_doubled;
                        send_next    = hrb_pkg::SEND_SYN;
                    end
                end
                else
                    ticks_next = ticks_inc;
            end
            else if (phase_reg == PH_WAIT_QUIET)
            begin
                if (head_ev == hrb_pkg::EV_TICK)
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= wait_reg)
                        phase_next = PH_CONNECTED;
                end
                else if (last_attempt)
                    phase_next = PH_FAILED;
                else
                begin
                    attempt_next = attempt_reg + 1'b1;
                    ticks_next   = '0;
                    send_next    = hrb_pkg::SEND_ACK;
                end
            end
        end

        unique case (phase_next)
            PH_IDLE:        status_next = hrb_pkg::ST_IDLE;
            PH_WAIT_SYNACK: status_next = hrb_pkg::ST_BUSY;
            PH_WAIT_QUIET:  status_next = hrb_pkg::ST_BUSY;
            PH_CONNECTED:   status_next = hrb_pkg::ST_CONNECTED;
            PH_FAILED:      status_next = hrb_pkg::ST_FAILED;
            default:        status_next = hrb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            attempt_reg      <= '0;
            wait_reg         <= '0;
            ticks_reg        <= '0;
            max_attempts_reg <= hrb_pkg::RST_MAX_ATTEMPTS;
            initial_wait_reg <= hrb_pkg::RST_INITIAL_WAIT;
            ack_quiet_reg    <= hrb_pkg::RST_ACK_QUIET;
            m_tvalid_reg     <= 1'b0;
            send_reg         <= hrb_pkg::SEND_NONE;
            status_reg       <= hrb_pkg::ST_IDLE;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hrb_pkg::CFG_MAX_ATTEMPTS:
                        max_attempts_reg <= cfg_data[hrb_pkg::CNT_W-1:0];
                    hrb_pkg::CFG_INITIAL_WAIT: initial_wait_reg <= cfg_data;
                    hrb_pkg::CFG_ACK_QUIET:    ack_quiet_reg    <= cfg_data;
                    default: ;
                endcase
            end

            if (pop)
            begin
                phase_reg    <= phase_next;
                attempt_reg  <= attempt_next;
                wait_reg     <= wait_next;
                ticks_reg    <= ticks_next;
                send_reg     <= send_next;
                status_reg   <= status_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

endmodule

// ----- rtl/handshake_retry_backoff_top.sv -----
// handshake retry backoff top level: front, event queue and back
// an event is registered in the queue, and its result is then registered in the output register
// throughput: one event per cycle while the output is taken, set by the state update in the back
// the two-entry queue and output register let input and output stall independently
// reset: asynchronous active low; idle phase, counters cleared, registers to defaults
module handshake_retry_backoff_top #(
    parameter int TIMER_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hrb_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hrb_pkg::TDATA_W-1:0]    s_tdata,   // is_synack, zero pad
    input  logic [hrb_pkg::OP_W-1:0]       s_tuser,   // operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hrb_pkg::TDATA_W-1:0]    m_tdata    // send_action, link_status, zero pad
);

    hrb_pkg::q_status_t q_status;
    hrb_pkg::ev_t       push_ev;
    hrb_pkg::ev_t       head_ev;
    logic               push;
    logic               pop;

    hrb_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .push_ev  (push_ev)
    );

    hrb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_ev (push_ev),
        .pop     (pop),
        .head_ev (head_ev),
        .status  (q_status)
    );

    hrb_back #(
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_ev    (head_ev),
        .head_valid (q_status.not_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    a_pop_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> m_tvalid)
        else $error("event taken without a result");

    a_send_code_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] <= hrb_pkg::SEND_ACK))
        else $error("unused send code");

    a_send_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != hrb_pkg::SEND_NONE)
            |-> (m_tdata[3:2] == hrb_pkg::ST_BUSY))
        else $error("segment sent outside handshake");

    a_queue_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.not_empty && !m_tvalid) |-> pop)
        else $error("queued event stalled with output free");

endmodule

// ----- tb/handshake_retry_backoff_top_test.sv -----
// self-checking testbench for the handshake retry backoff block
`timescale 1ns / 1ps

module handshake_retry_backoff_top_test;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int PHASE_ITEMS   = 310;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic [2:0] {
        LP_IDLE,
        LP_SYNACK,
        LP_QUIET,
        LP_CONNECTED,
        LP_FAILED
    } link_phase_t;

    typedef struct packed {
        logic [1:0] send;
        logic [1:0] status;
    } link_result_t;

    typedef struct {
        bit           is_cfg;
        logic [1:0]   index;
        logic [7:0]   value;
        logic [1:0]   op;
        logic         syn;
        bit           typed;
        link_result_t res;
    } plan_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [hrb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hrb_pkg::CFG_W-1:0]     cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [hrb_pkg::TDATA_W-1:0]   s_tdata;
    logic [hrb_pkg::OP_W-1:0]      s_tuser;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [hrb_pkg::TDATA_W-1:0]   m_tdata;

    // shadow of the block
    link_phase_t  hs_phase;
    logic [3:0]   tries;
    logic [15:0]  wait_len;
    logic [15:0]  waited;
    logic [3:0]   cfg_max;
    logic [7:0]   cfg_init;
    logic [7:0]   cfg_quiet;

    link_result_t pending_results[$];
    plan_row_t    plan[$];
    int           errors;
    int           cycle_count = 0;
    int           burst_left;
    int           gap_max;
    logic [9:0]   rx_count = '0;

    handshake_retry_backoff_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: ready, coin toss, short periodic stalls, long stalls
    always @(posedge clk)
    begin
        rx_count <= rx_count + 10'd1;
        case (rx_count[9:8])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= (rx_count[2:0] != 3'd7);
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < 40)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        link_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", m_tdata, 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] != want.send)
                    report_mismatch("send_action", m_tdata[1:0], want.send);
                if (m_tdata[3:2] != want.status)
                    report_mismatch("link_status", m_tdata[3:2], want.status);
                if (m_tdata[7:4] != 4'd0)
                    report_mismatch("tdata pad", m_tdata[7:4], 0);
            end
        end
    end

    // ends an attempt; returns 1 when the phase has run out of attempts
    function automatic bit attempt_spent();
        if (tries >= cfg_max)
        begin
            hs_phase = LP_FAILED;
            return 1'b1;
        end
        tries  = tries + 4'd1;
        waited = '0;
        return 1'b0;
    endfunction

    function automatic link_result_t handshake_step(input logic [1:0] op, input logic syn);
        link_result_t r;
        logic [16:0]  doubled;
        bit           expired;
        r.send  = hrb_pkg::SEND_NONE;
        if (op == hrb_pkg::OP_START)
        begin
            hs_phase = LP_SYNACK;
            tries    = 4'd1;
            wait_len = {8'd0, cfg_init};
            waited   = '0;
            r.send   = hrb_pkg::SEND_SYN;
        end
        else if ((op == hrb_pkg::OP_TICK || op == hrb_pkg::OP_SEG) && hs_phase == LP_SYNACK)
        begin
            if (op == hrb_pkg::OP_SEG && syn)
            begin
                hs_phase = LP_QUIET;
                tries    = 4'd1;
                wait_len = {8'd0, cfg_quiet};
                waited   = '0;
                r.send   = hrb_pkg::SEND_ACK;
            end
            else
            begin
                expired = 1'b1;
                if (op == hrb_pkg::OP_TICK)
                begin
                    if (waited != '1)
                        waited = waited + 16'd1;
                    expired = (waited >= wait_len);
                end
                if (expired && !attempt_spent())
                begin
                    doubled  = {wait_len, 1'b0};
                    wait_len = doubled[16] ? 16'hFFFF : doubled[15:0];
                    r.send   = hrb_pkg::SEND_SYN;
                end
            end
        end
        else if ((op == hrb_pkg::OP_TICK || op == hrb_pkg::OP_SEG) && hs_phase == LP_QUIET)
        begin
            if (op == hrb_pkg::OP_TICK)
            begin
                if (waited != '1)
                    waited = waited + 16'd1;
                if (waited >= wait_len)
                    hs_phase = LP_CONNECTED;
            end
            else if (!attempt_spent())
                r.send = hrb_pkg::SEND_ACK;
        end
        case (hs_phase)
            LP_SYNACK, LP_QUIET: r.status = hrb_pkg::ST_BUSY;
            LP_CONNECTED:        r.status = hrb_pkg::ST_CONNECTED;
            LP_FAILED:           r.status = hrb_pkg::ST_FAILED;
            default:             r.status = hrb_pkg::ST_IDLE;
        endcase
        return r;
    endfunction

    function automatic void plan_event(input logic [1:0] op, input logic syn);
        plan_row_t row;
        row        = '{default: '0};
        row.op     = op;
        row.syn    = syn;
        plan.push_back(row);
    endfunction

    function automatic void plan_known(input logic [1:0] op, input logic syn,
                                       input logic [1:0] send, input logic [1:0] status);
        plan_row_t row;
        row            = '{default: '0};
        row.op         = op;
        row.syn        = syn;
        row.typed      = 1'b1;
        row.res.send   = send;
        row.res.status = status;
        plan.push_back(row);
    endfunction

    function automatic void plan_write(input logic [1:0] index, input logic [7:0] value);
        plan_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.index  = index;
        row.value  = value;
        plan.push_back(row);
    endfunction

    task automatic send_event(input logic [1:0] op, input logic syn, input bit typed,
                              input link_result_t typed_res);
        int           gap;
        link_result_t predicted;
        if (burst_left == 0)
        begin
            gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, syn};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = handshake_step(op, syn);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (index)
            hrb_pkg::CFG_MAX_ATTEMPTS: cfg_max   = value[3:0];
            hrb_pkg::CFG_INITIAL_WAIT: cfg_init  = value;
            hrb_pkg::CFG_ACK_QUIET:    cfg_quiet = value;
            default:                   ;
        endcase
    endtask

    initial
    begin
        int           counted;
        int           seg_pct;
        int           pick;
        logic [1:0]   op;
        logic         syn;
        logic [7:0]   max_val;
        logic [7:0]   init_val;
        logic [7:0]   quiet_val;
        link_result_t none_res;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = hrb_pkg::OP_NONE;
        errors      = 0;
        burst_left  = 0;
        gap_max     = 4;
        seg_pct     = 20;
        none_res    = '0;
        hs_phase    = LP_IDLE;
        tries       = '0;
        wait_len    = '0;
        waited      = '0;
        cfg_max     = hrb_pkg::RST_MAX_ATTEMPTS;
        cfg_init    = hrb_pkg::RST_INITIAL_WAIT;
        cfg_quiet   = hrb_pkg::RST_ACK_QUIET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, register defaults first
        plan_known(hrb_pkg::OP_TICK, 1'b0, hrb_pkg::SEND_NONE, hrb_pkg::ST_IDLE);
        plan_known(hrb_pkg::OP_SEG, 1'b1, hrb_pkg::SEND_NONE, hrb_pkg::ST_IDLE);
        plan_known(hrb_pkg::OP_NONE, 1'b1, hrb_pkg::SEND_NONE, hrb_pkg::ST_IDLE);
        plan_known(hrb_pkg::OP_START, 1'b0, hrb_pkg::SEND_SYN, hrb_pkg::ST_BUSY);
        plan_event(hrb_pkg::OP_TICK, 1'b0);
        plan_event(hrb_pkg::OP_TICK, 1'b0);
        plan_event(hrb_pkg::OP_TICK, 1'b0);
        plan_event(hrb_pkg::OP_SEG, 1'b0);
        plan_event(hrb_pkg::OP_NONE, 1'b1);
        plan_event(hrb_pkg::OP_TICK, 1'b1);
        plan_event(hrb_pkg::OP_SEG, 1'b1);
        plan_event(hrb_pkg::OP_SEG, 1'b0);
        repeat (5) plan_event(hrb_pkg::OP_TICK, 1'b0);
        plan_known(hrb_pkg::OP_TICK, 1'b0, hrb_pkg::SEND_NONE, hrb_pkg::ST_CONNECTED);
        plan_known(hrb_pkg::OP_START, 1'b0, hrb_pkg::SEND_SYN, hrb_pkg::ST_BUSY);
        plan_event(hrb_pkg::OP_SEG, 1'b1);
        plan_known(hrb_pkg::OP_START, 1'b1, hrb_pkg::SEND_SYN, hrb_pkg::ST_BUSY);
        // zero attempts acts as one, zero wait expires on the first tick
        plan_write(hrb_pkg::CFG_MAX_ATTEMPTS, 8'd0);
        plan_write(hrb_pkg::CFG_INITIAL_WAIT, 8'd0);
        plan_known(hrb_pkg::OP_START, 1'b0, hrb_pkg::SEND_SYN, hrb_pkg::ST_BUSY);
        plan_known(hrb_pkg::OP_SEG, 1'b0, hrb_pkg::SEND_NONE, hrb_pkg::ST_FAILED);
        plan_known(hrb_pkg::OP_TICK, 1'b0, hrb_pkg::SEND_NONE, hrb_pkg::ST_FAILED);
        plan_known(hrb_pkg::OP_START, 1'b0, hrb_pkg::SEND_SYN, hrb_pkg::ST_BUSY);
        plan_known(hrb_pkg::OP_TICK, 1'b0, hrb_pkg::SEND_NONE, hrb_pkg::ST_FAILED);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain_results();
                write_reg(plan[i].index, plan[i].value);
            end
            else
                send_event(plan[i].op, plan[i].syn, plan[i].typed, plan[i].res);
        end

        // random part, one register setting per phase
        for (int p = 0; p < 6; p++)
        begin
            drain_results();
            case (p)
                0:
                begin
                    max_val = 8'd15; init_val = 8'd255; quiet_val = 8'd255;
                end
                1:
                begin
                    max_val = 8'd1; init_val = 8'd1; quiet_val = 8'd1;
                end
                2:
                begin
                    max_val = 8'd0; init_val = 8'd0; quiet_val = 8'd0;
                end
                3:
                begin
                    max_val   = 8'($urandom_range(0, 255));
                    init_val  = 8'($urandom_range(1, 12));
                    quiet_val = 8'($urandom_range(1, 12));
                end
                4:
                begin
                    max_val   = 8'($urandom_range(2, 6));
                    init_val  = 8'($urandom_range(1, 4));
                    quiet_val = 8'($urandom_range(1, 6));
                end
                default:
                begin
                    max_val = 8'(hrb_pkg::RST_MAX_ATTEMPTS); init_val = hrb_pkg::RST_INITIAL_WAIT;
                    quiet_val = hrb_pkg::RST_ACK_QUIET;
                end
            endcase
            write_reg(hrb_pkg::CFG_ACK_QUIET, quiet_val);
            write_reg(hrb_pkg::CFG_MAX_ATTEMPTS, max_val);
            write_reg(hrb_pkg::CFG_INITIAL_WAIT, init_val);
            gap_max = (p == 5) ? 0 : $urandom_range(1, 6);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                syn  = 1'($urandom_range(0, 1));
                if (hs_phase == LP_SYNACK || hs_phase == LP_QUIET)
                begin
                    if (pick < 2)
                        op = hrb_pkg::OP_START;
                    else if (pick < 4)
                        op = hrb_pkg::OP_NONE;
                    else if (pick < 4 + seg_pct)
                        op = hrb_pkg::OP_SEG;
                    else
                        op = hrb_pkg::OP_TICK;
                end
                else if (pick < 70)
                    op = hrb_pkg::OP_START;
                else if (pick < 85)
                    op = hrb_pkg::OP_TICK;
                else if (pick < 95)
                    op = hrb_pkg::OP_SEG;
                else
                    op = hrb_pkg::OP_NONE;
                if (op == hrb_pkg::OP_START)
                    seg_pct = $urandom_range(3, 40);
                send_event(op, syn, 1'b0, none_res);
                counted++;
            end
        end

        // drive the wait into saturation, then check it has not wrapped to zero
        drain_results();
        write_reg(hrb_pkg::CFG_MAX_ATTEMPTS, 8'd15);
        write_reg(hrb_pkg::CFG_INITIAL_WAIT, 8'd128);
        write_reg(hrb_pkg::CFG_ACK_QUIET, 8'd1);
        gap_max = 1;
        send_event(hrb_pkg::OP_START, 1'b0, 1'b0, none_res);
        repeat (9) send_event(hrb_pkg::OP_SEG, 1'b0, 1'b0, none_res);
        repeat (16) send_event(hrb_pkg::OP_TICK, 1'b0, 1'b0, none_res);
        send_event(hrb_pkg::OP_SEG, 1'b1, 1'b0, none_res);
        send_event(hrb_pkg::OP_TICK, 1'b0, 1'b0, none_res);

        drain_results();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results left over", pending_results.size(), 0);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
